// ----- rtl/core/erm_pkg.sv -----
// erm_pkg: shared widths, types and helper functions for the euler to rotation matrix unit
// no dependencies; imported by every module of the block
`default_nettype none

package erm_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int ENTRY_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int FRAC        = 30;
    localparam int ANGLE_SHIFT = FRAC - (ANGLE_WIDTH - 3);
    localparam int CW          = 34;
    localparam int SC_W        = 32;
    localparam int PROD_W      = 64;
    localparam int SUM_W       = 66;
    localparam int ENTRY_SHIFT = 2 * FRAC - (ENTRY_WIDTH - 2);
    localparam int NUM_ENTRIES = 9;
    localparam int TABLE_LEN   = 30;
    localparam int IDX_W       = 5;

    localparam int IN_W   = ((3 * ANGLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_W  = ((NUM_ENTRIES * ENTRY_WIDTH + 7) / 8) * 8;

    localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);
    localparam logic signed [CW-1:0] PI_Q30      = CW'(64'sd3373259426);
    localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'sd1686629713);

    localparam logic signed [PROD_W-1:0] HALF_Q30 = PROD_W'(64'sd1) <<< (FRAC - 1);
    localparam logic signed [SUM_W-1:0]  HALF_OUT = SUM_W'(64'sd1) <<< (ENTRY_SHIFT - 1);
    localparam logic signed [SUM_W-1:0]  ONE_OUT  = SUM_W'(64'sd1) <<< (ENTRY_WIDTH - 2);

    localparam logic [31:0] ATAN_TBL [TABLE_LEN] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } rot_t;

    typedef struct packed {
        logic           valid;
        rot_t [2:0]     rot;
    } cell_t;

    typedef logic [ENTRY_WIDTH-1:0] entry_t;
    typedef entry_t [NUM_ENTRIES-1:0] matrix_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        return CW'(ATAN_TBL[idx]);
    endfunction

    function automatic entry_t to_entry(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = (v + HALF_OUT) >>> ENTRY_SHIFT;
        if (t > ONE_OUT) begin
            t = ONE_OUT;
        end else if (t < -ONE_OUT) begin
            t = -ONE_OUT;
        end
        return t[ENTRY_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/euler_to_rotation_matrix_unit.sv -----
// euler_to_rotation_matrix_unit: top level, angle folding, cordic cell chain, output skid
// depends on erm_pkg, erm_cordic_cell, erm_matrix
`default_nettype none

// Takes one roll, pitch, yaw beat (Q2.13 radians, any 16-bit value) and returns
// the nine ZYX direction cosine entries in Q1.14, rounded and saturated to +-1.0.
// One beat is accepted every cycle while the skid register is empty. An input beat passes
// through one fold register, one cordic cell per step, three product and sum stages
// and the output register. A two-entry output register and skid stage keep the input
// side open while one result waits; the input side closes while the skid entry is full.

module euler_to_rotation_matrix_unit
    import erm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // roll_angle, pitch_angle, yaw_angle
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

    cell_t   chain [CORDIC_STEPS+1];
    cell_t   fold_reg, fold_next;
    logic    en;
    logic    mat_valid;
    matrix_t mat_data;
    matrix_t out_reg, skid_reg;
    logic    m_tvalid_reg, skid_valid_reg;
    logic signed [CW-1:0] z_in;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_comb begin
        fold_next.valid = s_tvalid;
        z_in = '0;
        for (int a = 0; a < 3; a++) begin
            z_in = CW'($signed(s_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH])) <<< ANGLE_SHIFT;
            fold_next.rot[a].x    = GAIN_Q30;
            fold_next.rot[a].y    = '0;
            fold_next.rot[a].flip = 1'b0;
            fold_next.rot[a].z    = z_in;
            if (z_in > HALF_PI_Q30) begin
                fold_next.rot[a].z    = z_in - PI_Q30;
                fold_next.rot[a].flip = 1'b1;
            end else if (z_in < -HALF_PI_Q30) begin
                fold_next.rot[a].z    = z_in + PI_Q30;
                fold_next.rot[a].flip = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg.valid <= 1'b0;
        end else if (en) begin
            fold_reg <= fold_next;
        end
    end

    assign chain[0] = fold_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        erm_cordic_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .step     (IDX_W'(k)),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    erm_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cell_in   (chain[CORDIC_STEPS]),
        .mat_valid (mat_valid),
        .mat_data  (mat_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (mat_valid) begin
                if (!m_tvalid_reg || m_tready) begin
                    out_reg      <= mat_data;
                    m_tvalid_reg <= 1'b1;
                end else begin
                    skid_reg       <= mat_data;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(out_reg);

endmodule

`default_nettype wire

// ----- rtl/core/erm_cordic_cell.sv -----
// erm_cordic_cell: one rotation step of the cordic for all three angles, registered
// depends on erm_pkg
`default_nettype none

module erm_cordic_cell
    import erm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [IDX_W-1:0] step,
    input  wire cell_t            cell_in,
    output cell_t                 cell_out
);

    cell_t cell_reg;
    cell_t cell_next;
    logic signed [CW-1:0] angle_step;

    always_comb begin
        angle_step = atan_q30(step);
        cell_next  = cell_in;
        for (int a = 0; a < 3; a++) begin
            if (!cell_in.rot[a].z[CW-1]) begin
                cell_next.rot[a].x = cell_in.rot[a].x - (cell_in.rot[a].y >>> step);
                cell_next.rot[a].y = cell_in.rot[a].y + (cell_in.rot[a].x >>> step);
                cell_next.rot[a].z = cell_in.rot[a].z - angle_step;
            end else begin
                cell_next.rot[a].x = cell_in.rot[a].x + (cell_in.rot[a].y >>> step);
                cell_next.rot[a].y = cell_in.rot[a].y - (cell_in.rot[a].x >>> step);
                cell_next.rot[a].z = cell_in.rot[a].z + angle_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// ----- rtl/core/erm_matrix.sv -----
// erm_matrix: three-stage product and sum pipeline from sines and cosines to matrix entries
// depends on erm_pkg
`default_nettype none

module erm_matrix
    import erm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire cell_t cell_in,
    output logic       mat_valid,
    output matrix_t    mat_data
);

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SC_W-1:0]   sc_t;

    typedef struct packed {
        prod_t ct_cp, ct_sp, sr_ct, cr_ct, cr_sp, sr_sp, cr_cp, sr_cp, sr_st, cr_st;
        sc_t   st, sp, cp;
    } stage1_t;

    typedef struct packed {
        prod_t ct_cp, ct_sp, sr_ct, cr_ct, cr_sp, sr_sp, cr_cp, sr_cp;
        prod_t srst_cp, crst_cp, srst_sp, crst_sp;
        sc_t   st;
    } stage2_t;

    sc_t sc [6];
    logic signed [CW-1:0] neg_val;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    matrix_t s3_reg, s3_next;
    logic v1_reg, v2_reg, v3_reg;
    logic signed [PROD_W-1:0] srst_full, crst_full;
    sc_t srst, crst;

    always_comb begin
        neg_val = '0;
        for (int a = 0; a < 3; a++) begin
            neg_val       = cell_in.rot[a].flip ? -cell_in.rot[a].y : cell_in.rot[a].y;
            sc[2*a]       = neg_val[SC_W-1:0];
            neg_val       = cell_in.rot[a].flip ? -cell_in.rot[a].x : cell_in.rot[a].x;
            sc[2*a+1]     = neg_val[SC_W-1:0];
        end
        // sc order: sr, cr, st, ct, sp, cp
        s1_next.ct_cp = sc[3] * sc[5];
        s1_next.ct_sp = sc[3] * sc[4];
        s1_next.sr_ct = sc[0] * sc[3];
        s1_next.cr_ct = sc[1] * sc[3];
        s1_next.cr_sp = sc[1] * sc[4];
        s1_next.sr_sp = sc[0] * sc[4];
        s1_next.cr_cp = sc[1] * sc[5];
        s1_next.sr_cp = sc[0] * sc[5];
        s1_next.sr_st = sc[0] * sc[2];
        s1_next.cr_st = sc[1] * sc[2];
        s1_next.st    = sc[2];
        s1_next.sp    = sc[4];
        s1_next.cp    = sc[5];
    end

    always_comb begin
        srst_full = (s1_reg.sr_st + HALF_Q30) >>> FRAC;
        crst_full = (s1_reg.cr_st + HALF_Q30) >>> FRAC;
        srst      = srst_full[SC_W-1:0];
        crst      = crst_full[SC_W-1:0];
        s2_next.ct_cp   = s1_reg.ct_cp;
        s2_next.ct_sp   = s1_reg.ct_sp;
        s2_next.sr_ct   = s1_reg.sr_ct;
        s2_next.cr_ct   = s1_reg.cr_ct;
        s2_next.cr_sp   = s1_reg.cr_sp;
        s2_next.sr_sp   = s1_reg.sr_sp;
        s2_next.cr_cp   = s1_reg.cr_cp;
        s2_next.sr_cp   = s1_reg.sr_cp;
        s2_next.srst_cp = srst * s1_reg.cp;
        s2_next.crst_cp = crst * s1_reg.cp;
        s2_next.srst_sp = srst * s1_reg.sp;
        s2_next.crst_sp = crst * s1_reg.sp;
        s2_next.st      = s1_reg.st;
    end

    always_comb begin
        s3_next[0] = to_entry(SUM_W'(s2_reg.ct_cp));
        s3_next[1] = to_entry(SUM_W'(s2_reg.srst_cp) - SUM_W'(s2_reg.cr_sp));
        s3_next[2] = to_entry(SUM_W'(s2_reg.sr_sp) + SUM_W'(s2_reg.crst_cp));
        s3_next[3] = to_entry(SUM_W'(s2_reg.ct_sp));
        s3_next[4] = to_entry(SUM_W'(s2_reg.cr_cp) + SUM_W'(s2_reg.srst_sp));
        s3_next[5] = to_entry(SUM_W'(s2_reg.crst_sp) - SUM_W'(s2_reg.sr_cp));
        s3_next[6] = to_entry(-(SUM_W'(s2_reg.st) <<< FRAC));
        s3_next[7] = to_entry(SUM_W'(s2_reg.sr_ct));
        s3_next[8] = to_entry(SUM_W'(s2_reg.cr_ct));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= cell_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign mat_valid = v3_reg;
    assign mat_data  = s3_reg;

endmodule

`default_nettype wire

// ----- rtl/core/erm_checker.sv -----
// erm_checker: port-level assertions for euler_to_rotation_matrix_unit, with its bind
// depends on erm_pkg
`default_nettype none

module erm_checker
    import erm_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    function automatic logic entries_in_range(input logic [OUT_W-1:0] d);
        logic ok;
        logic signed [ENTRY_WIDTH-1:0] e;
        ok = 1'b1;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            e = $signed(d[k*ENTRY_WIDTH +: ENTRY_WIDTH]);
            if (SUM_W'(e) > ONE_OUT || SUM_W'(e) < -ONE_OUT) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> entries_in_range(m_tdata))
        else $error("matrix entry beyond unit range");

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input held off with empty output");

endmodule

bind euler_to_rotation_matrix_unit erm_checker u_erm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for euler_to_rotation_matrix_unit, predicts the zyx matrix per beat
// depends on erm_pkg and the rtl of the block; stimulus is directed angles then random ones
`default_nettype none

module tb_top;
    import erm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint GAIN   = 652032874;
    localparam longint PI30   = 64'sd3373259426;
    localparam longint HPI30  = 1686629713;
    localparam longint LIMIT  = 400000;
    localparam int     LAT    = CORDIC_STEPS + 5;

    localparam longint ATAN [TABLE_LEN] = '{
        843314857, 497837830, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    matrix_t expected_matrices[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_recv = 1'b0;
    longint cycles = 0;

    euler_to_rotation_matrix_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic void cordic_sincos(logic [15:0] raw, output longint sn,
                                          output longint cs);
        longint x, y, z, dx, dy;
        bit flip;
        x = GAIN;
        y = 0;
        flip = 0;
        z = longint'($signed(raw)) <<< ANGLE_SHIFT;
        if (z > HPI30) begin
            z -= PI30;
            flip = 1;
        end else if (z < -HPI30) begin
            z += PI30;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN[i];
            end else begin
                x += dx; y -= dy; z += ATAN[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic longint triple_product(longint a, longint b, longint c);
        return round_shift(a * b, FRAC) * c;
    endfunction

    function automatic entry_t round_entry(longint q60);
        longint one, v;
        one = longint'(1) <<< (ENTRY_WIDTH - 2);
        v = round_shift(q60, ENTRY_SHIFT);
        if (v > one) v = one;
        if (v < -one) v = -one;
        return v[ENTRY_WIDTH-1:0];
    endfunction

    function automatic matrix_t rotation_matrix(logic [15:0] roll, logic [15:0] pitch,
                                                logic [15:0] yaw);
        longint sr, cr, st, ct, sp, cp;
        matrix_t m;
        cordic_sincos(roll, sr, cr);
        cordic_sincos(pitch, st, ct);
        cordic_sincos(yaw, sp, cp);
        m[0] = round_entry(ct * cp);
        m[1] = round_entry(-(cr * sp) + triple_product(sr, st, cp));
        m[2] = round_entry(sr * sp + triple_product(cr, st, cp));
        m[3] = round_entry(ct * sp);
        m[4] = round_entry(cr * cp + triple_product(sr, st, sp));
        m[5] = round_entry(-(sr * cp) + triple_product(cr, st, sp));
        m[6] = round_entry(-st * (longint'(1) <<< FRAC));
        m[7] = round_entry(sr * ct);
        m[8] = round_entry(cr * ct);
        return m;
    endfunction

    task automatic report_mismatch(string what, int idx, entry_t got, entry_t want);
        $display("mismatch %s entry %0d: got %0d want %0d", what, idx,
                 $signed(got), $signed(want));
        errors++;
    endtask

    task automatic send_angles(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = IN_W'({yaw, pitch, roll});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_matrices.push_back(rotation_matrix(roll, pitch, yaw));
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // receiver handshake and checking
    always @(negedge aclk) begin
        if (hold_recv) m_tready <= 1'b0;
        else m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge aclk) begin
        matrix_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[NUM_ENTRIES*ENTRY_WIDTH-1:0];
            if (expected_matrices.size() == 0) begin
                $display("unexpected result beat");
                errors++;
            end else begin
                want = expected_matrices.pop_front();
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (got[i] !== want[i]) report_mismatch("matrix", i, got[i], want[i]);
            end
        end
    end

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(51472) - 25736);
            1: return 16'($urandom_range(65535));
            2: return 16'($urandom_range(12868, 12870));
            default: return 16'(-$signed(17'($urandom_range(12868, 12870))));
        endcase
    endfunction

    task automatic wait_drained();
        while (expected_matrices.size() != 0) @(negedge aclk);
    endtask

    task automatic test_directed();
        logic [15:0] corners [10] = '{16'h0000, 16'd25736, -16'sd25736, 16'd12868,
            -16'sd12868, 16'd12869, 16'h7fff, 16'h8000, 16'hffff, 16'd6434};
        for (int i = 0; i < 10; i++) send_angles(corners[i], corners[(i + 3) % 10],
                                                 corners[(i + 7) % 10]);
        send_angles(16'd12868, 16'd12868, 16'd12868);
        send_angles(16'h7fff, 16'h8000, 16'h7fff);
        send_angles(16'h5555, 16'haaaa, 16'h0001);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_recv = 1'b1;
                repeat (200) @(posedge aclk);
                hold_recv = 1'b0;
            end
            test_random(60);
        join
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        send_idle_pct = 33; recv_idle_pct = 53;
        test_random(130);
        send_idle_pct = 53; recv_idle_pct = 33;
        test_random(130);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(100);
        test_backpressure();
        repeat (LAT + 10) @(negedge aclk);
        if (errors == 0 && expected_matrices.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire
